### sv/frequency_sweep_sequencer_core_defines.svh
// assertion helpers for the sweep sequencer
// every check is sampled on the rising edge of clock and is off while reset is high
`ifndef FREQUENCY_SWEEP_SEQUENCER_CORE_DEFINES_SVH
`define FREQUENCY_SWEEP_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define FSS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sweep sequencer check failed");

// next-cycle implication
`define FSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sweep sequencer check failed");

`endif

### sv/fss_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fss_pkg;

   localparam int FREQ_BITS_DEFAULT = 27;

   // register file index
   localparam int CSR_ADDR_BITS = 3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_START_FREQ    = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STOP_FREQ     = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_STEP_FREQ     = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_SWEEP_PATTERN = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_REPEAT_ON     = 3'd4;

   // reset values, cut to the frequency width where they are used
   localparam logic [63:0] START_FREQ_RESET = 64'd10000;
   localparam logic [63:0] STOP_FREQ_RESET  = 64'd100000;
   localparam logic [63:0] STEP_FREQ_RESET  = 64'd1000;

   // sweep patterns
   localparam logic [1:0] PAT_UP      = 2'd0;
   localparam logic [1:0] PAT_DOWN    = 2'd1;
   localparam logic [1:0] PAT_UP_DOWN = 2'd2;
   localparam logic [1:0] PAT_DOWN_UP = 2'd3;

   typedef struct packed {
      logic [1:0] pattern;
      logic       repeat_on;
   } sweep_mode_type;

   typedef struct packed {
      logic write_freq;
      logic target_register;
      logic output_changed;
      logic output_on;
      logic is_running;
      logic sweep_done;
   } rsp_flags_type;

endpackage

`default_nettype wire

### sv/fss_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module fss_csr #(
   parameter int FREQ_BITS = fss_pkg::FREQ_BITS_DEFAULT
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [fss_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [FREQ_BITS-1:0]             csr_wdata,
   output logic [FREQ_BITS-1:0]                  start_freq,
   output logic [FREQ_BITS-1:0]                  stop_freq,
   output logic [FREQ_BITS-1:0]                  step_freq,
   output fss_pkg::sweep_mode_type               mode
);
   import fss_pkg::*;

   logic [FREQ_BITS-1:0] start_ff;
   logic [FREQ_BITS-1:0] stop_ff;
   logic [FREQ_BITS-1:0] step_ff;
   sweep_mode_type       mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff          <= START_FREQ_RESET[FREQ_BITS-1:0];
         stop_ff           <= STOP_FREQ_RESET[FREQ_BITS-1:0];
         step_ff           <= STEP_FREQ_RESET[FREQ_BITS-1:0];
         mode_ff.pattern   <= PAT_UP;
         mode_ff.repeat_on <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_START_FREQ:    start_ff          <= csr_wdata;
            CSR_STOP_FREQ:     stop_ff           <= csr_wdata;
            CSR_STEP_FREQ:     step_ff           <= csr_wdata;
            CSR_SWEEP_PATTERN: mode_ff.pattern   <= csr_wdata[1:0];
            CSR_REPEAT_ON:     mode_ff.repeat_on <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign start_freq = start_ff;
   assign stop_freq  = stop_ff;
   assign step_freq  = step_ff;
   assign mode       = mode_ff;

endmodule

`default_nettype wire

### sv/fss_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module fss_engine #(
   parameter int FREQ_BITS = fss_pkg::FREQ_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 accept,
   input  wire logic                 kind,
   input  wire logic                 timer_fired,
   input  wire logic [FREQ_BITS-1:0] start_freq,
   input  wire logic [FREQ_BITS-1:0] stop_freq,
   input  wire logic [FREQ_BITS-1:0] step_freq,
   input  fss_pkg::sweep_mode_type   mode,
   output fss_pkg::rsp_flags_type    flags,
   output logic [FREQ_BITS-1:0]      freq_value
);
   import fss_pkg::*;

   localparam int CUR_BITS = FREQ_BITS + 2;

   logic                       running_ff, running_in;
   logic                       active_ff, active_in;
   logic                       first_ff, first_in;
   logic                       done_ff, done_in;
   logic                       out_en_ff, out_en_in;
   logic signed [CUR_BITS-1:0] cur_ff, cur_in;

   logic signed [CUR_BITS-1:0] lo_ext, hi_ext, step_ext;
   logic                       le_hi, ge_lo;
   logic [FREQ_BITS-1:0]       sat_val;
   logic                       step_req, step_up;
   logic                       wr;
   logic                       wr_reg;
   logic [FREQ_BITS-1:0]       wr_val;

   assign lo_ext   = $signed({2'b00, start_freq});
   assign hi_ext   = $signed({2'b00, stop_freq});
   assign step_ext = $signed({2'b00, step_freq});
   assign le_hi    = (cur_ff <= hi_ext);
   assign ge_lo    = (cur_ff >= lo_ext);

   // clamp the running value into the field before it is written
   always_comb begin
      if (cur_ff[CUR_BITS-1]) begin
         sat_val = '0;
      end else if (|cur_ff[CUR_BITS-2:FREQ_BITS]) begin
         sat_val = '1;
      end else begin
         sat_val = cur_ff[FREQ_BITS-1:0];
      end
   end

   always_comb begin
      running_in = running_ff;
      active_in  = active_ff;
      first_in   = first_ff;
      done_in    = done_ff;
      out_en_in  = out_en_ff;
      cur_in     = cur_ff;
      step_req   = 1'b0;
      step_up    = 1'b0;
      wr         = 1'b0;
      wr_reg     = 1'b0;
      wr_val     = '0;

      if (kind) begin
         if (running_ff) begin
            running_in = 1'b0;
            out_en_in  = 1'b0;
         end else begin
            running_in = 1'b1;
            active_in  = 1'b0;
            cur_in     = mode.pattern[0] ? hi_ext : lo_ext;
            wr         = 1'b1;
            wr_val     = mode.pattern[0] ? stop_freq : start_freq;
            out_en_in  = 1'b1;
            first_in   = 1'b1;
            done_in    = 1'b0;
         end
      end else if (running_ff) begin
         case (mode.pattern)
            PAT_UP: begin
               if (le_hi) begin
                  step_req = timer_fired;
                  step_up  = 1'b1;
               end else begin
                  cur_in  = lo_ext;
                  done_in = 1'b1;
               end
            end
            PAT_DOWN: begin
               if (ge_lo) begin
                  step_req = timer_fired;
               end else begin
                  cur_in  = hi_ext;
                  done_in = 1'b1;
               end
            end
            PAT_UP_DOWN: begin
               if (first_ff && le_hi) begin
                  step_req = timer_fired;
                  step_up  = 1'b1;
               end else if (first_ff) begin
                  first_in = 1'b0;
               end else if (ge_lo) begin
                  step_req = timer_fired;
               end else begin
                  done_in  = 1'b1;
                  first_in = 1'b1;
               end
            end
            default: begin
               if (first_ff && ge_lo) begin
                  step_req = timer_fired;
               end else if (first_ff) begin
                  first_in = 1'b0;
               end else if (le_hi) begin
                  step_req = timer_fired;
                  step_up  = 1'b1;
               end else begin
                  done_in  = 1'b1;
                  first_in = 1'b1;
               end
            end
         endcase

         // write the active register, then ping-pong
         if (step_req) begin
            wr        = 1'b1;
            wr_reg    = active_ff;
            wr_val    = sat_val;
            cur_in    = step_up ? (cur_ff + step_ext) : (cur_ff - step_ext);
            active_in = ~active_ff;
         end

         // single run ends once the final endpoint of the sweep has been passed
         if (!mode.repeat_on && done_in) begin
            running_in = 1'b0;
            out_en_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b0;
         active_ff  <= 1'b0;
         first_ff   <= 1'b1;
         done_ff    <= 1'b0;
         out_en_ff  <= 1'b0;
         cur_ff     <= '0;
      end else if (accept) begin
         running_ff <= running_in;
         active_ff  <= active_in;
         first_ff   <= first_in;
         done_ff    <= done_in;
         out_en_ff  <= out_en_in;
         cur_ff     <= cur_in;
      end
   end

   assign flags.write_freq      = wr;
   assign flags.target_register = wr_reg;
   assign flags.output_changed  = out_en_in ^ out_en_ff;
   assign flags.output_on       = out_en_in;
   assign flags.is_running      = running_in;
   assign flags.sweep_done      = done_in;
   assign freq_value            = wr_val;

endmodule

`default_nettype wire

### sv/fss_rsp_reg.sv
`timescale 1ns / 1ps
`default_nettype none

module fss_rsp_reg #(
   parameter int FREQ_BITS = fss_pkg::FREQ_BITS_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 load,
   input  fss_pkg::rsp_flags_type    flags_in,
   input  wire logic [FREQ_BITS-1:0] freq_in,
   input  wire logic                 rsp_tready,
   output logic                      rsp_valid,
   output fss_pkg::rsp_flags_type    flags_out,
   output logic [FREQ_BITS-1:0]      freq_out,
   output logic                      in_ready
);
   import fss_pkg::*;

   logic           valid_ff;
   rsp_flags_type  flags_ff;
   logic [FREQ_BITS-1:0] freq_ff;

   // a new result may replace the held one in the cycle it is taken
   assign in_ready = ~valid_ff | rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         flags_ff <= flags_in;
         freq_ff  <= freq_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign flags_out = flags_ff;
   assign freq_out  = freq_ff;

endmodule

`default_nettype wire

### sv/frequency_sweep_sequencer_core.sv
// linear frequency sweep sequencer, one result transfer for every request transfer
// latency: the result is valid in the cycle after the request transfer
// throughput: one request per cycle while ready is high; the state update and result are one compare/add pass
// ready drops only while a held result is not taken
// reset is synchronous and active high: sweep stopped, output off, registers at defaults
`timescale 1ns / 1ps
`default_nettype none
`include "frequency_sweep_sequencer_core_defines.svh"

module frequency_sweep_sequencer_core #(
   parameter int FREQ_BITS = fss_pkg::FREQ_BITS_DEFAULT,
   localparam int RSP_BITS = FREQ_BITS + 6,
   localparam int RSP_DATA_BITS = ((RSP_BITS + 7) / 8) * 8
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request channel
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [7:0]                        req_tdata,  // [0] timer_fired
   input  wire logic                              req_tuser,  // [0] kind: 0 poll, 1 start/stop
   // result channel
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // low to high: write_freq, target_register, freq_value, output_changed,
   // output_on, is_running, sweep_done, zero fill
   output logic [RSP_DATA_BITS-1:0]               rsp_tdata,
   // register writes
   input  wire logic                              csr_we,
   input  wire logic [fss_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [FREQ_BITS-1:0]              csr_wdata
);
   import fss_pkg::*;

   logic [FREQ_BITS-1:0] start_freq;
   logic [FREQ_BITS-1:0] stop_freq;
   logic [FREQ_BITS-1:0] step_freq;
   sweep_mode_type       mode;

   logic                 req_xfer;
   rsp_flags_type        next_flags;
   logic [FREQ_BITS-1:0] next_freq;
   rsp_flags_type        rsp_flags;
   logic [FREQ_BITS-1:0] rsp_freq;

   // sweep endpoints, step and mode
   fss_csr #(
      .FREQ_BITS (FREQ_BITS)
   ) u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .start_freq (start_freq),
      .stop_freq  (stop_freq),
      .step_freq  (step_freq),
      .mode       (mode)
   );

   // a request transfer advances the sweep state and builds its result
   assign req_xfer = req_tvalid & req_tready;

   fss_engine #(
      .FREQ_BITS (FREQ_BITS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_xfer),
      .kind        (req_tuser),
      .timer_fired (req_tdata[0]),
      .start_freq  (start_freq),
      .stop_freq   (stop_freq),
      .step_freq   (step_freq),
      .mode        (mode),
      .flags       (next_flags),
      .freq_value  (next_freq)
   );

   // result register decouples the two channels
   fss_rsp_reg #(
      .FREQ_BITS (FREQ_BITS)
   ) u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (req_xfer),
      .flags_in   (next_flags),
      .freq_in    (next_freq),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .flags_out  (rsp_flags),
      .freq_out   (rsp_freq),
      .in_ready   (req_tready)
   );

   // pack result fields, lowest first
   always_comb begin
      rsp_tdata = '0;
      rsp_tdata[RSP_BITS-1:0] = {rsp_flags.sweep_done, rsp_flags.is_running,
                                 rsp_flags.output_on, rsp_flags.output_changed,
                                 rsp_freq, rsp_flags.target_register,
                                 rsp_flags.write_freq};
   end

   // output enable follows the run state
   `FSS_ASSERT_NOW(a_out_follows_run, rsp_tvalid, rsp_flags.output_on == rsp_flags.is_running)
   // no write means no register and no frequency on the bus
   `FSS_ASSERT_NOW(a_idle_write_zero, rsp_tvalid && !rsp_flags.write_freq,
                   rsp_freq == '0 && !rsp_flags.target_register)
   // a start/stop transfer always flips the output enable
   `FSS_ASSERT_NEXT(a_toggle_flips, req_xfer && req_tuser,
                    rsp_tvalid && rsp_flags.output_changed)
   // an enable change without a write can only be a stop
   `FSS_ASSERT_NOW(a_change_no_write_off,
                   rsp_tvalid && rsp_flags.output_changed && !rsp_flags.write_freq,
                   !rsp_flags.output_on)

endmodule

`default_nettype wire
